/* hw/rtl/txcw_pkg.sv */
// Package for the text console writer: screen geometry, derived widths,
// command codes and control character codes. No dependencies.
package txcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_BYTES = 2;

  localparam int CHAR_W       = 8;
  localparam int CELL_W       = CELL_BYTES * CHAR_W;
  localparam int CELL_COUNT   = ROWS * COLUMNS;
  localparam int ADDR_W       = $clog2(CELL_COUNT);
  localparam int COL_W        = $clog2(COLUMNS);
  localparam int COL_EXT_W    = COL_W + 1;
  localparam int ROW_W        = $clog2(ROWS);
  localparam int COPY_CELLS   = (ROWS - 2) * COLUMNS;
  localparam int TAB_STOP     = 8;

  localparam int CMD_W        = 2;
  localparam int CELL_INDEX_W = 11;
  localparam int CURSOR_POS_W = 11;
  localparam int SUM_W        = (ADDR_W > CURSOR_POS_W) ? ADDR_W : CURSOR_POS_W;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LINE_FEED = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

endpackage

/* hw/rtl/text_console_writer_unit.sv */
// Text console writer top level: cursor logic, sequencer and frame buffer.
// Depends on txcw_pkg and txcw_ram.
//
// This block keeps a text screen of ROWS x COLUMNS cells, each a character
// byte with an attribute byte above it, in one frame buffer RAM. After reset
// the sequencer sweeps all CELL_COUNT cells (2000 at 80 x 25) to zero, one
// cell per cycle, and in_ready stays low until that sweep is done. Every
// request returns exactly one result that carries the linear cursor position
// row*COLUMNS+col. A printable character is written to its cell in the accept
// cycle, and the result is loaded in the finish state once the output
// register is free. Backspace and a cell read pass through a state of their
// own (S_BSWR, S_READ) before the finish state, since they wait for the
// registered RAM read. A put that pushes the cursor onto the last row
// scrolls the screen: the buffer port copies one cell per cycle for
// (ROWS-2)*COLUMNS cells, then zeroes the bottom two rows one cell per cycle.
// A clear request zeroes the whole buffer the same way. The RAM has one write
// and one read port, and that single port pair sets the pace of every long
// pass. The result sits in an output register, so a new request is taken
// while an earlier result still waits for out_ready.
module text_console_writer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [txcw_pkg::CMD_W-1:0]           cmd,
  input  logic [txcw_pkg::CHAR_W-1:0]          ch,
  input  logic [txcw_pkg::CHAR_W-1:0]          attr,
  input  logic [txcw_pkg::CELL_INDEX_W-1:0]    cell_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [txcw_pkg::CURSOR_POS_W-1:0]    cursor_pos,
  output logic [txcw_pkg::CHAR_W-1:0]          read_char,
  output logic [txcw_pkg::CHAR_W-1:0]          read_attr
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BSWR,
    S_READ,
    S_SCROLL,
    S_FINISH
  } state_t;

  state_t state;

  // Cursor and sequencer registers.
  logic [txcw_pkg::COL_W-1:0]  col;
  logic [txcw_pkg::ROW_W-1:0]  row;
  logic [txcw_pkg::ADDR_W-1:0] scan;
  logic                        pend;
  logic [txcw_pkg::ADDR_W-1:0] pend_addr;
  logic                        reply;
  logic                        rd_hit;
  logic [txcw_pkg::CHAR_W-1:0] res_char;
  logic [txcw_pkg::CHAR_W-1:0] res_attr;

  // Frame buffer ports.
  logic                        ram_we;
  logic [txcw_pkg::ADDR_W-1:0] ram_waddr;
  logic [txcw_pkg::CELL_W-1:0] ram_wdata;
  logic [txcw_pkg::ADDR_W-1:0] ram_raddr;
  logic [txcw_pkg::CELL_W-1:0] ram_rdata;

  // Combinational cursor step for a put request.
  logic                           accept;
  logic [txcw_pkg::ADDR_W-1:0]    cur_idx;
  logic [txcw_pkg::COL_EXT_W-1:0] ncol;
  logic [txcw_pkg::ROW_W-1:0]     nrow;
  logic                           put_bs;
  logic                           put_wr;
  logic                           put_scroll;
  logic                           rd_in_range;
  logic [txcw_pkg::SUM_W-1:0]     pos_sum;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign cur_idx = txcw_pkg::ADDR_W'(row) * txcw_pkg::ADDR_W'(txcw_pkg::COLUMNS)
                 + txcw_pkg::ADDR_W'(col);
  assign pos_sum = txcw_pkg::SUM_W'(row) * txcw_pkg::SUM_W'(txcw_pkg::COLUMNS)
                 + txcw_pkg::SUM_W'(col);
  assign rd_in_range = txcw_pkg::SUM_W'(cell_index) < txcw_pkg::SUM_W'(txcw_pkg::CELL_COUNT);

  always_comb begin
    ncol       = {1'b0, col};
    nrow       = row;
    put_bs     = 1'b0;
    put_wr     = 1'b0;
    put_scroll = 1'b0;
    case (ch)
      txcw_pkg::CH_BACKSPACE: begin
        // Backspace at the left edge does nothing at all.
        if (col != '0) begin
          ncol   = {1'b0, col} - 1'b1;
          put_bs = 1'b1;
        end
      end
      txcw_pkg::CH_TAB: begin
        ncol = ({1'b0, col} + txcw_pkg::COL_EXT_W'(txcw_pkg::TAB_STOP))
             & ~txcw_pkg::COL_EXT_W'(txcw_pkg::TAB_STOP - 1);
      end
      txcw_pkg::CH_RETURN: begin
        ncol = '0;
      end
      txcw_pkg::CH_LINE_FEED: begin
        ncol = '0;
        nrow = row + 1'b1;
      end
      default: begin
        put_wr = 1'b1;
        ncol   = {1'b0, col} + 1'b1;
      end
    endcase
    if (ncol >= txcw_pkg::COL_EXT_W'(txcw_pkg::COLUMNS)) begin
      ncol = '0;
      nrow = nrow + 1'b1;
    end
    // Reaching the last row scrolls the screen and moves the cursor up one.
    if (nrow >= txcw_pkg::ROW_W'(txcw_pkg::ROWS - 1)) begin
      nrow       = nrow - 1'b1;
      put_scroll = 1'b1;
    end
  end

  // Frame buffer port selection by sequencer state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan;
    ram_wdata = '0;
    ram_raddr = txcw_pkg::ADDR_W'(cell_index);
    case (state)
      S_IDLE: begin
        if (cmd == txcw_pkg::CMD_PUT) begin
          // The read serves backspace, which keeps the attribute of the cell.
          ram_raddr = cur_idx - 1'b1;
          if (accept && put_wr) begin
            ram_we    = 1'b1;
            ram_waddr = cur_idx;
            ram_wdata = {attr, ch};
          end
        end
      end
      S_BSWR: begin
        ram_we    = 1'b1;
        ram_waddr = pend_addr;
        ram_wdata = {ram_rdata[txcw_pkg::CELL_W-1:txcw_pkg::CHAR_W], txcw_pkg::CHAR_W'(0)};
      end
      S_SCROLL: begin
        // Read one row ahead, write the cell fetched in the previous cycle.
        ram_raddr = scan + txcw_pkg::ADDR_W'(txcw_pkg::COLUMNS);
        ram_we    = pend;
        ram_waddr = pend_addr;
        ram_wdata = ram_rdata;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan;
        ram_wdata = '0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  txcw_ram #(
    .WIDTH (txcw_pkg::CELL_W),
    .DEPTH (txcw_pkg::CELL_COUNT)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan      <= '0;
      col       <= '0;
      row       <= '0;
      pend      <= 1'b0;
      reply     <= 1'b0;
      rd_hit    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The finish state decides the output register on its own.
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (scan == txcw_pkg::ADDR_W'(txcw_pkg::CELL_COUNT - 1)) begin
            scan  <= '0;
            // The sweep after reset owes no result; a clear or scroll does.
            state <= reply ? S_FINISH : S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_char <= '0;
            res_attr <= '0;
            reply    <= 1'b1;
            case (cmd)
              txcw_pkg::CMD_PUT: begin
                col       <= txcw_pkg::COL_W'(ncol);
                row       <= nrow;
                pend_addr <= cur_idx - 1'b1;
                scan      <= '0;
                if (put_bs) begin
                  state <= S_BSWR;
                end else if (put_scroll) begin
                  state <= S_SCROLL;
                end else begin
                  state <= S_FINISH;
                end
              end
              txcw_pkg::CMD_CLEAR: begin
                col   <= '0;
                row   <= '0;
                scan  <= '0;
                state <= S_CLEAR;
              end
              txcw_pkg::CMD_READ: begin
                rd_hit <= rd_in_range;
                state  <= S_READ;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_BSWR: begin
          state <= S_FINISH;
        end
        S_READ: begin
          if (rd_hit) begin
            res_char <= ram_rdata[txcw_pkg::CHAR_W-1:0];
            res_attr <= ram_rdata[txcw_pkg::CELL_W-1:txcw_pkg::CHAR_W];
          end
          state <= S_FINISH;
        end
        S_SCROLL: begin
          // The last copy drains here; scan already points at the first
          // cell of the two rows that the zero sweep clears.
          if (scan == txcw_pkg::ADDR_W'(txcw_pkg::COPY_CELLS)) begin
            pend  <= 1'b0;
            state <= S_CLEAR;
          end else begin
            pend      <= 1'b1;
            pend_addr <= scan;
            scan      <= scan + 1'b1;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            cursor_pos <= pos_sum[txcw_pkg::CURSOR_POS_W-1:0];
            read_char  <= res_char;
            read_attr  <= res_attr;
            reply      <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/txcw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module txcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_unit: directed and random console
// requests checked against a screen model kept inside the bench.
// Depends on txcw_pkg and the text_console_writer_unit RTL.
module tb;

  // The command field is two bits wide, and the fourth code has no meaning.
  // The block must leave the screen alone and return zero read fields for it.
  localparam logic [txcw_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam int RANDOM_REQUESTS  = 900;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int LONG_HOLD_AFTER  = 200;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 40;

  typedef struct packed {
    logic [txcw_pkg::CMD_W-1:0]        cmd;
    logic [txcw_pkg::CHAR_W-1:0]       ch;
    logic [txcw_pkg::CHAR_W-1:0]       attr;
    logic [txcw_pkg::CELL_INDEX_W-1:0] cell_index;
  } console_request_t;

  typedef struct packed {
    logic [txcw_pkg::CURSOR_POS_W-1:0] cursor_pos;
    logic [txcw_pkg::CHAR_W-1:0]       read_char;
    logic [txcw_pkg::CHAR_W-1:0]       read_attr;
  } console_result_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_SPARSE} ready_mode_t;

  logic                              clk        = 1'b0;
  logic                              rst        = 1'b1;
  logic                              in_valid   = 1'b0;
  logic                              in_ready;
  logic [txcw_pkg::CMD_W-1:0]        cmd        = txcw_pkg::CMD_PUT;
  logic [txcw_pkg::CHAR_W-1:0]       ch         = '0;
  logic [txcw_pkg::CHAR_W-1:0]       attr       = '0;
  logic [txcw_pkg::CELL_INDEX_W-1:0] cell_index = '0;
  logic                              out_valid;
  logic                              out_ready  = 1'b0;
  logic [txcw_pkg::CURSOR_POS_W-1:0] cursor_pos;
  logic [txcw_pkg::CHAR_W-1:0]       read_char;
  logic [txcw_pkg::CHAR_W-1:0]       read_attr;

  text_console_writer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .ch         (ch),
    .attr       (attr),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_pos (cursor_pos),
    .read_char  (read_char),
    .read_attr  (read_attr)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Screen model. Each cell keeps the attribute in the upper byte and the
  // character in the lower byte, exactly as the frame buffer does.
  // ---------------------------------------------------------------------------
  logic [txcw_pkg::CELL_W-1:0] screen_cells [txcw_pkg::CELL_COUNT];
  int unsigned                 cur_col;
  int unsigned                 cur_row;

  console_request_t  pending_requests [$];
  console_result_t   expected_results [$];
  int                error_count    = 0;
  int                requests_taken = 0;
  int                stimulus_count = 0;
  int                quiet_cycles   = 0;

  function automatic void clear_screen_model();
    foreach (screen_cells[i]) screen_cells[i] = '0;
    cur_col = 0;
    cur_row = 0;
  endfunction

  // One put-character step: control characters move the cursor, anything
  // else lands in the cell under the cursor. Wrapping off the right edge and
  // landing on the last row are resolved afterwards, in that order.
  function automatic void put_character(logic [txcw_pkg::CHAR_W-1:0] c,
                                        logic [txcw_pkg::CHAR_W-1:0] a);
    int unsigned idx;
    int          i;
    case (c)
      txcw_pkg::CH_BACKSPACE: begin
        // Backspace at the left margin is a no-op. Elsewhere it blanks only
        // the character byte and leaves the old attribute in place.
        if (cur_col > 0) begin
          cur_col--;
          idx = cur_row * txcw_pkg::COLUMNS + cur_col;
          screen_cells[idx[txcw_pkg::ADDR_W-1:0]][txcw_pkg::CHAR_W-1:0] = '0;
        end
      end
      txcw_pkg::CH_TAB: begin
        cur_col = (cur_col + txcw_pkg::TAB_STOP) & ~(txcw_pkg::TAB_STOP - 1);
      end
      txcw_pkg::CH_RETURN: cur_col = 0;
      txcw_pkg::CH_LINE_FEED: begin
        cur_col = 0;
        cur_row++;
      end
      default: begin
        idx = cur_row * txcw_pkg::COLUMNS + cur_col;
        screen_cells[idx[txcw_pkg::ADDR_W-1:0]] = {a, c};
        cur_col++;
      end
    endcase
    if (cur_col >= txcw_pkg::COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    // Scroll: everything moves up one row, and the bottom two rows come back
    // blank, so the cursor never sits on the last row after a step.
    if (cur_row >= txcw_pkg::ROWS - 1) begin
      for (i = 0; i < (txcw_pkg::ROWS - 1) * txcw_pkg::COLUMNS; i++) begin
        screen_cells[txcw_pkg::ADDR_W'(i)] =
          screen_cells[txcw_pkg::ADDR_W'(i + txcw_pkg::COLUMNS)];
      end
      for (i = (txcw_pkg::ROWS - 2) * txcw_pkg::COLUMNS; i < txcw_pkg::CELL_COUNT; i++) begin
        screen_cells[txcw_pkg::ADDR_W'(i)] = '0;
      end
      cur_row--;
    end
  endfunction

  function automatic console_result_t predict_console(console_request_t r);
    console_result_t res;
    int unsigned     pos;
    res = '0;
    case (r.cmd)
      txcw_pkg::CMD_PUT:   put_character(r.ch, r.attr);
      txcw_pkg::CMD_CLEAR: clear_screen_model();
      txcw_pkg::CMD_READ: begin
        // Reads past the end of the screen return zeros.
        if (r.cell_index < txcw_pkg::CELL_COUNT) begin
          res.read_char = screen_cells[r.cell_index][txcw_pkg::CHAR_W-1:0];
          res.read_attr = screen_cells[r.cell_index][txcw_pkg::CELL_W-1:txcw_pkg::CHAR_W];
        end
      end
      default: ;
    endcase
    pos = cur_row * txcw_pkg::COLUMNS + cur_col;
    res.cursor_pos = pos[txcw_pkg::CURSOR_POS_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation. Fields that a command ignores still get random values
  // so that every input bit toggles.
  // ---------------------------------------------------------------------------
  function automatic void queue_request(logic [txcw_pkg::CMD_W-1:0] c,
                                        logic [txcw_pkg::CHAR_W-1:0] chr,
                                        logic [txcw_pkg::CHAR_W-1:0] at,
                                        logic [txcw_pkg::CELL_INDEX_W-1:0] idx);
    console_request_t r;
    r.cmd        = c;
    r.ch         = chr;
    r.attr       = at;
    r.cell_index = idx;
    pending_requests.push_back(r);
    // Reserved commands leave the block untouched and do not count as work.
    if (c != CMD_RESERVED) stimulus_count++;
  endfunction

  function automatic logic [txcw_pkg::CHAR_W-1:0] rand_byte();
    return txcw_pkg::CHAR_W'($urandom);
  endfunction

  function automatic void queue_put(logic [txcw_pkg::CHAR_W-1:0] chr,
                                    logic [txcw_pkg::CHAR_W-1:0] at);
    queue_request(txcw_pkg::CMD_PUT, chr, at, txcw_pkg::CELL_INDEX_W'($urandom));
  endfunction

  function automatic void queue_read(logic [txcw_pkg::CELL_INDEX_W-1:0] idx);
    queue_request(txcw_pkg::CMD_READ, rand_byte(), rand_byte(), idx);
  endfunction

  // Mostly plain ASCII, with the odd arbitrary byte (control codes included).
  function automatic logic [txcw_pkg::CHAR_W-1:0] pick_text_byte();
    if ($urandom_range(0, 4) != 0) return txcw_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E));
    return rand_byte();
  endfunction

  // Most reads land on the screen; some fall just past it or anywhere in the
  // full index range.
  function automatic logic [txcw_pkg::CELL_INDEX_W-1:0] pick_cell_index();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      return txcw_pkg::CELL_INDEX_W'($urandom_range(0, txcw_pkg::CELL_COUNT - 1));
    end
    if (sel == 7) begin
      return txcw_pkg::CELL_INDEX_W'($urandom_range(txcw_pkg::CELL_COUNT,
                                                    2 ** txcw_pkg::CELL_INDEX_W - 1));
    end
    return txcw_pkg::CELL_INDEX_W'($urandom);
  endfunction

  // One burst of console traffic shaped like real use: runs of text, line
  // ends, tabs, erasing, read-back, and now and then a clear or plain noise.
  function automatic void queue_random_sequence();
    int kind;
    int n;
    int i;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // Long runs now and then, so that lines wrap at the right edge.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 20);
      for (i = 0; i < n; i++) queue_put(pick_text_byte(), rand_byte());
    end else if (kind < 50) begin
      if ($urandom_range(0, 1) != 0) queue_put(txcw_pkg::CH_RETURN, rand_byte());
      queue_put(txcw_pkg::CH_LINE_FEED, rand_byte());
    end else if (kind < 58) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) begin
        queue_put(txcw_pkg::CH_TAB, rand_byte());
        if ($urandom_range(0, 2) == 0) queue_put(pick_text_byte(), rand_byte());
      end
    end else if (kind < 64) begin
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++) queue_put(txcw_pkg::CH_BACKSPACE, rand_byte());
    end else if (kind < 84) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) queue_read(pick_cell_index());
    end else if (kind < 89) begin
      // A flood of line feeds drives the cursor to the bottom and scrolls.
      n = $urandom_range(5, 25);
      for (i = 0; i < n; i++) queue_put(txcw_pkg::CH_LINE_FEED, rand_byte());
    end else if (kind < 91) begin
      queue_request(txcw_pkg::CMD_CLEAR, rand_byte(), rand_byte(),
                    txcw_pkg::CELL_INDEX_W'($urandom));
    end else if (kind < 94) begin
      queue_request(CMD_RESERVED, rand_byte(), rand_byte(),
                    txcw_pkg::CELL_INDEX_W'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        queue_request(txcw_pkg::CMD_W'($urandom), rand_byte(), rand_byte(),
                      txcw_pkg::CELL_INDEX_W'($urandom));
      end
    end
  endfunction

  // Holds the sender back until the block has returned every result.
  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Requests go out in bursts of random length separated by
  // random gaps; some bursts are long enough to run back to back for a while.
  // The payload only changes when the slot is free or was just taken.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    console_request_t next_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_req   = pending_requests.pop_front();
        cmd        <= next_req.cmd;
        ch         <= next_req.ch;
        attr       <= next_req.attr;
        cell_index <= next_req.cell_index;
        in_valid   <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. It switches between always ready, coin-flip and mostly
  // stalled. Once, after enough requests have gone in, it refuses results for
  // a long stretch while the driver keeps offering, so the output register
  // fills and the block has to push back on its input.
  // ---------------------------------------------------------------------------
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left  = 0;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && requests_taken >= LONG_HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(20, 400);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_RANDOM: out_ready <= ($urandom_range(0, 1) != 0);
        default:      out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Results are checked before the request of the same edge is
  // predicted, since a result can never leave in the cycle its request enters.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    console_result_t  want;
    console_request_t seen;
    if (rst) begin
      clear_screen_model();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result with no request outstanding, expected none, got cursor_pos %0d",
                   $time, cursor_pos);
        end else begin
          want = expected_results.pop_front();
          check_field("cursor_pos", int'(want.cursor_pos), int'(cursor_pos));
          check_field("read_char", int'(want.read_char), int'(read_char));
          check_field("read_attr", int'(want.read_attr), int'(read_attr));
        end
      end
      if (in_valid && in_ready) begin
        seen.cmd        = cmd;
        seen.ch         = ch;
        seen.attr       = attr;
        seen.cell_index = cell_index;
        expected_results.push_back(predict_console(seen));
        requests_taken <= requests_taken + 1;
      end
    end
  end

  // Watchdog: any stretch without a single handshake on either side that
  // outlasts the slowest pass over the buffer by far means the block hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL text_console_writer_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: the screen comes up blank, reads at and past the end,
    // the reserved command, character bytes at both extremes, backspace in
    // the middle of a line and at the left margin, tabs, return, line feed,
    // and a clear that wipes everything again.
    queue_read(txcw_pkg::CELL_INDEX_W'(0));
    queue_read('1);
    queue_request(CMD_RESERVED, '1, '1, '0);
    queue_put("A", 8'hFF);
    queue_put(8'h00, 8'h00);
    queue_put(8'hFF, 8'h80);
    queue_read(txcw_pkg::CELL_INDEX_W'(0));
    queue_read(txcw_pkg::CELL_INDEX_W'(1));
    queue_read(txcw_pkg::CELL_INDEX_W'(2));
    queue_put(txcw_pkg::CH_BACKSPACE, 8'h00);
    queue_read(txcw_pkg::CELL_INDEX_W'(2));
    queue_put(txcw_pkg::CH_RETURN, 8'h00);
    queue_put(txcw_pkg::CH_BACKSPACE, 8'hFF);
    queue_put(txcw_pkg::CH_TAB, 8'h00);
    queue_put(txcw_pkg::CH_TAB, 8'h00);
    queue_put("x", 8'h1E);
    queue_read(txcw_pkg::CELL_INDEX_W'(16));
    queue_put(txcw_pkg::CH_LINE_FEED, 8'h00);
    queue_read(txcw_pkg::CELL_INDEX_W'(txcw_pkg::CELL_COUNT - 1));
    queue_read(txcw_pkg::CELL_INDEX_W'(txcw_pkg::CELL_COUNT));
    queue_read(txcw_pkg::CELL_INDEX_W'(1024));
    queue_request(txcw_pkg::CMD_CLEAR, '0, '0, '1);
    queue_read(txcw_pkg::CELL_INDEX_W'(0));
    queue_request(CMD_RESERVED, 8'h5A, 8'hA5, txcw_pkg::CELL_INDEX_W'(1234));
    wait_for_drain();

    // Random traffic in two halves. Between them the driver sits idle until
    // every outstanding result is back.
    stimulus_count = 0;
    while (stimulus_count < RANDOM_REQUESTS / 2) queue_random_sequence();
    wait_for_drain();
    while (stimulus_count < RANDOM_REQUESTS) queue_random_sequence();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS text_console_writer_unit");
    end else begin
      $display("FAIL text_console_writer_unit");
    end
    $finish;
  end

endmodule

/* text_console_writer_unit.f */
hw/rtl/txcw_pkg.sv
hw/rtl/txcw_ram.sv
hw/rtl/text_console_writer_unit.sv
tb/sv/tb.sv
